FILE: sv/fpn_pkg.sv
// shared types, constants and functions of the fractal perlin noise core
// no dependencies
package fpn_pkg;

   localparam int unsigned FracBits  = 16;
   localparam int unsigned CoordBits = FracBits + 8;
   localparam int unsigned MulBits   = 33;
   localparam int unsigned ProdBits  = 2 * MulBits;
   localparam int unsigned DivBits   = 46;
   localparam int unsigned DivCntBits = 6;
   localparam int unsigned SumBits   = 24;

   localparam logic [1:0] RegOctaves     = 2'd0;
   localparam logic [1:0] RegPersistence = 2'd1;
   localparam logic [1:0] RegLacunarity  = 2'd2;

   localparam logic CmdTableWrite = 1'b0;
   localparam logic CmdQuery      = 1'b1;

   typedef struct packed {
      logic       en;
      logic [7:0] addr;
      logic [7:0] data;
   } perm_wr_type;

   // 8-way gradient: +-u +- 2v
   function automatic logic signed [19:0] grad(input logic [2:0] h,
                                               input logic signed [17:0] x,
                                               input logic signed [17:0] y);
      logic signed [19:0] u;
      logic signed [19:0] v;
      logic signed [19:0] r1;
      logic signed [19:0] r2;
      u  = h[2] ? 20'(y) : 20'(x);
      v  = h[2] ? 20'(x) : 20'(y);
      r1 = h[0] ? -u : u;
      r2 = h[1] ? -(v <<< 1) : (v <<< 1);
      return r1 + r2;
   endfunction

endpackage

FILE: sv/fpn_perm_ram.sv
// permutation table memory, one write port and one registered read port
// uses fpn_pkg
module fpn_perm_ram (
   input  logic                clock,
   input  fpn_pkg::perm_wr_type wr,
   input  logic [7:0]          rd_addr,
   output logic [7:0]          rd_data_ff
);
   import fpn_pkg::*;

   logic [7:0] mem [256];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

endmodule

FILE: sv/fpn_divider.sv
// restoring divider, one quotient bit per cycle
// uses fpn_pkg
module fpn_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          go,
   input  logic [fpn_pkg::DivBits-1:0]   dividend,
   input  logic [fpn_pkg::SumBits-1:0]   divisor,
   output logic                          done_ff,
   output logic [fpn_pkg::DivBits-1:0]   quot_ff
);
   import fpn_pkg::*;

   logic [SumBits-1:0]    rem_ff, rem_in;
   logic [SumBits-1:0]    den_ff;
   logic [DivCntBits-1:0] cnt_ff;
   logic                  run_ff;
   logic [SumBits:0]      rem_sh;
   logic                  fits;

   always_comb begin
      rem_sh = {rem_ff, quot_ff[DivBits-1]};
      fits   = rem_sh >= {1'b0, den_ff};
      rem_in = fits ? SumBits'(rem_sh - {1'b0, den_ff}) : rem_sh[SumBits-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (go) begin
            run_ff  <= 1'b1;
            cnt_ff  <= '0;
            rem_ff  <= '0;
            den_ff  <= divisor;
            quot_ff <= dividend;
         end else if (run_ff) begin
            rem_ff  <= rem_in;
            quot_ff <= {quot_ff[DivBits-2:0], fits};
            cnt_ff  <= cnt_ff + 1'b1;
            if (cnt_ff == DivCntBits'(DivBits - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

endmodule

FILE: sv/fractal_perlin_noise_2d_core.sv
// fractal 2d perlin noise core: sequencer, shared multiplier and csr port
// uses fpn_pkg, fpn_perm_ram, fpn_divider
// table write: no result; busy stays low
// query: each octave runs the sequencer states on the shared 33x33 multiplier, then the divide
// (skipped when the amplitude sum is zero); busy blocks new items, no result stall
// synchronous active-high reset; table contents undefined until written
module fractal_perlin_noise_2d_core #(
   parameter int unsigned MAX_OCTAVES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_cmd,
   input  logic [7:0]  req_table_index,
   input  logic [7:0]  req_table_value,
   input  logic signed [31:0] req_coord_x,
   input  logic signed [31:0] req_coord_y,
   output logic        rsp_valid,
   output logic signed [16:0] rsp_noise_value,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import fpn_pkg::*;

   localparam logic [5:0] MaxOct = 6'(MAX_OCTAVES);

   typedef enum logic [4:0] {
      S_IDLE, S_SX, S_SY, S_TX, S_T2X, S_QX, S_TY, S_T2Y, S_QY,
      S_L1, S_L2, S_L3, S_ACC, S_AMP, S_FRQ, S_NXT, S_DIV, S_WAIT
   } state_type;

   state_type state_ff, state_in;

   logic [4:0]  octcnt_ff;
   logic [15:0] pers_ff, lac_ff;

   logic [4:0]  oct_ff, oct_in;
   logic signed [31:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [CoordBits-1:0] lx_ff, lx_in, ly_ff, ly_in;
   logic [15:0] t2_ff, t2_in;
   logic [16:0] fadex_ff, fadex_in, fadey_ff, fadey_in;
   logic [7:0]  pa_ff, pa_in, pb_ff, pb_in;
   logic [2:0]  haa_ff, haa_in, hab_ff, hab_in, hba_ff, hba_in, hbb_ff, hbb_in;
   logic signed [20:0] r1_ff, r1_in;
   logic signed [31:0] total_ff, total_in;
   logic [16:0] amp_ff, amp_in;
   logic [SumBits-1:0] asum_ff, asum_in;
   logic [31:0] freq_ff, freq_in;
   logic signed [ProdBits-1:0] prod_ff;
   logic signed [MulBits-1:0] mul_a, mul_b;
   logic        busy_ff, busy_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic signed [16:0] res_ff, res_in;

   perm_wr_type tbl_wr;
   logic [7:0]  rd_addr;
   logic [7:0]  rd_data;
   logic        div_go;
   logic        div_done;
   logic [DivBits-1:0] div_quot;
   logic [DivBits-1:0] dividend;

   logic [5:0]  oct_lim;
   logic        accept;
   logic        csr_wr;
   logic [15:0] xf, yf, tf;
   logic [7:0]  xi, yi;
   logic signed [17:0] x0, x1, y0, y1;
   logic signed [19:0] g_aa, g_ab, g_ba, g_bb;
   logic [21:0] qpoly;
   logic signed [21:0] lerp_sum;
   logic signed [33:0] acc_sum;
   logic [35:0] freq_scaled;
   logic        neg;
   logic [31:0] mag;

   assign accept     = start && !busy_ff;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign busy       = busy_ff;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_noise_value = res_ff;

   always_comb begin
      case (csr_paddr[3:2])
         RegOctaves:     csr_prdata = {27'd0, octcnt_ff};
         RegPersistence: csr_prdata = {16'd0, pers_ff};
         RegLacunarity:  csr_prdata = {16'd0, lac_ff};
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         octcnt_ff <= 5'd4;
         pers_ff   <= 16'd32768;
         lac_ff    <= 16'd8192;
      end else if (csr_wr) begin
         case (csr_paddr[3:2])
            RegOctaves:     octcnt_ff <= csr_pwdata[4:0];
            RegPersistence: pers_ff   <= csr_pwdata[15:0];
            RegLacunarity:  lac_ff    <= csr_pwdata[15:0];
            default:        ;
         endcase
      end
   end

   assign tbl_wr.en   = accept && (req_cmd == CmdTableWrite);
   assign tbl_wr.addr = req_table_index;
   assign tbl_wr.data = req_table_value;

   fpn_perm_ram u_ram (
      .clock      (clock),
      .wr         (tbl_wr),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data)
   );

   fpn_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .go       (div_go),
      .dividend (dividend),
      .divisor  (asum_ff),
      .done_ff  (div_done),
      .quot_ff  (div_quot)
   );

   always_comb begin
      if (octcnt_ff == 5'd0) begin
         oct_lim = 6'd1;
      end else if ({1'b0, octcnt_ff} > MaxOct) begin
         oct_lim = MaxOct;
      end else begin
         oct_lim = {1'b0, octcnt_ff};
      end
   end

   // lattice split and corner gradients
   always_comb begin
      xf = lx_ff[FracBits-1:0];
      yf = ly_ff[FracBits-1:0];
      xi = lx_ff[CoordBits-1:FracBits];
      yi = ly_ff[CoordBits-1:FracBits];
      x0 = $signed({2'b00, xf});
      y0 = $signed({2'b00, yf});
      x1 = x0 - 18'sd65536;
      y1 = y0 - 18'sd65536;
      g_aa = grad(haa_ff, x0, y0);
      g_ba = grad(hba_ff, x1, y0);
      g_ab = grad(hab_ff, x0, y1);
      g_bb = grad(hbb_ff, x1, y1);
      tf   = (state_ff == S_QX) ? xf : yf;
      qpoly = 22'd655360 + 22'(t2_ff) * 22'd6 - 22'(tf) * 22'd15;
      lerp_sum = 22'(r1_ff) + $signed(prod_ff[37:16]);
      acc_sum  = 34'(total_ff) + $signed(prod_ff[49:16]);
      freq_scaled = prod_ff[47:12];
      neg = total_ff[31];
      mag = neg ? 32'(-total_ff) : 32'(total_ff);
      dividend = {mag, 14'd0};
   end

   always_comb begin
      state_in = state_ff;
      oct_in = oct_ff;
      cx_in = cx_ff;  cy_in = cy_ff;
      lx_in = lx_ff;  ly_in = ly_ff;
      t2_in = t2_ff;
      fadex_in = fadex_ff;  fadey_in = fadey_ff;
      pa_in = pa_ff;  pb_in = pb_ff;
      haa_in = haa_ff;  hab_in = hab_ff;  hba_in = hba_ff;  hbb_in = hbb_ff;
      r1_in = r1_ff;
      total_in = total_ff;  amp_in = amp_ff;  asum_in = asum_ff;  freq_in = freq_ff;
      busy_in = busy_ff;
      rsp_valid_in = 1'b0;
      res_in = res_ff;
      mul_a = '0;
      mul_b = '0;
      rd_addr = xi;
      div_go = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept && (req_cmd == CmdQuery)) begin
               cx_in = req_coord_x;
               cy_in = req_coord_y;
               oct_in = '0;
               total_in = '0;
               amp_in = 17'd65536;
               asum_in = '0;
               freq_in = 32'd4096;
               busy_in = 1'b1;
               state_in = S_SX;
            end
         end
         S_SX: begin
            mul_a = MulBits'(cx_ff);
            mul_b = $signed({1'b0, freq_ff});
            state_in = S_SY;
         end
         S_SY: begin
            lx_in = prod_ff[35:12];
            mul_a = MulBits'(cy_ff);
            mul_b = $signed({1'b0, freq_ff});
            state_in = S_TX;
         end
         S_TX: begin
            ly_in = prod_ff[35:12];
            mul_a = $signed({17'd0, xf});
            mul_b = $signed({17'd0, xf});
            rd_addr = xi;
            state_in = S_T2X;
         end
         S_T2X: begin
            t2_in = prod_ff[31:16];
            mul_a = $signed({17'd0, prod_ff[31:16]});
            mul_b = $signed({17'd0, xf});
            pa_in = rd_data;
            rd_addr = xi + 8'd1;
            state_in = S_QX;
         end
         S_QX: begin
            mul_a = $signed({17'd0, prod_ff[31:16]});
            mul_b = $signed({11'd0, qpoly});
            pb_in = rd_data;
            rd_addr = pa_ff + yi;
            state_in = S_TY;
         end
         S_TY: begin
            fadex_in = prod_ff[32:16];
            mul_a = $signed({17'd0, yf});
            mul_b = $signed({17'd0, yf});
            haa_in = rd_data[2:0];
            rd_addr = pa_ff + yi + 8'd1;
            state_in = S_T2Y;
         end
         S_T2Y: begin
            t2_in = prod_ff[31:16];
            mul_a = $signed({17'd0, prod_ff[31:16]});
            mul_b = $signed({17'd0, yf});
            hab_in = rd_data[2:0];
            rd_addr = pb_ff + yi;
            state_in = S_QY;
         end
         S_QY: begin
            mul_a = $signed({17'd0, prod_ff[31:16]});
            mul_b = $signed({11'd0, qpoly});
            hba_in = rd_data[2:0];
            rd_addr = pb_ff + yi + 8'd1;
            state_in = S_L1;
         end
         S_L1: begin
            fadey_in = prod_ff[32:16];
            hbb_in = rd_data[2:0];
            mul_a = $signed({16'd0, fadex_ff});
            mul_b = MulBits'(21'(g_ba) - 21'(g_aa));
            r1_in = 21'(g_aa);
            state_in = S_L2;
         end
         S_L2: begin
            r1_in = lerp_sum[20:0];
            mul_a = $signed({16'd0, fadex_ff});
            mul_b = MulBits'(21'(g_bb) - 21'(g_ab));
            state_in = S_L3;
         end
         S_L3: begin
            // r1_ff still holds the first lerp; the second base is g_ab
            mul_a = $signed({16'd0, fadey_ff});
            mul_b = MulBits'(21'(g_ab) + 21'($signed(prod_ff[37:16])) - r1_ff);
            state_in = S_ACC;
         end
         S_ACC: begin
            mul_a = MulBits'($signed(lerp_sum[20:0]));
            mul_b = $signed({16'd0, amp_ff});
            state_in = S_AMP;
         end
         S_AMP: begin
            if (acc_sum > 34'sd2147483647) begin
               total_in = 32'sh7FFFFFFF;
            end else if (acc_sum < -34'sd2147483648) begin
               total_in = 32'sh80000000;
            end else begin
               total_in = acc_sum[31:0];
            end
            asum_in = asum_ff + SumBits'(amp_ff);
            mul_a = $signed({16'd0, amp_ff});
            mul_b = $signed({17'd0, pers_ff});
            state_in = S_FRQ;
         end
         S_FRQ: begin
            amp_in = prod_ff[32:16];
            mul_a = $signed({1'b0, freq_ff});
            mul_b = $signed({17'd0, lac_ff});
            state_in = S_NXT;
         end
         S_NXT: begin
            freq_in = (|freq_scaled[35:32]) ? 32'hFFFFFFFF : freq_scaled[31:0];
            oct_in = oct_ff + 5'd1;
            if (6'(oct_ff) + 6'd1 == oct_lim) begin
               state_in = S_DIV;
            end else begin
               state_in = S_SX;
            end
         end
         S_DIV: begin
            if (asum_ff == '0) begin
               res_in = '0;
               rsp_valid_in = 1'b1;
               busy_in = 1'b0;
               state_in = S_IDLE;
            end else begin
               div_go = 1'b1;
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            if (div_done) begin
               if (!neg) begin
                  res_in = (|div_quot[DivBits-1:16]) ? 17'sd65535
                                                     : $signed({1'b0, div_quot[15:0]});
               end else begin
                  res_in = (|div_quot[DivBits-1:16]) ? -17'sd65536
                                                     : -$signed({1'b0, div_quot[15:0]});
               end
               rsp_valid_in = 1'b1;
               busy_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
            busy_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         oct_ff       <= '0;
         total_ff     <= '0;
         amp_ff       <= 17'd65536;
         asum_ff      <= '0;
         freq_ff      <= 32'd4096;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         oct_ff       <= oct_in;
         total_ff     <= total_in;
         amp_ff       <= amp_in;
         asum_ff      <= asum_in;
         freq_ff      <= freq_in;
      end
      cx_ff <= cx_in;  cy_ff <= cy_in;
      lx_ff <= lx_in;  ly_ff <= ly_in;
      t2_ff <= t2_in;
      fadex_ff <= fadex_in;  fadey_ff <= fadey_in;
      pa_ff <= pa_in;  pb_ff <= pb_in;
      haa_ff <= haa_in;  hab_ff <= hab_in;  hba_ff <= hba_in;  hbb_ff <= hbb_in;
      r1_ff <= r1_in;
      res_ff <= res_in;
      prod_ff <= mul_a * mul_b;
   end

`ifndef SYNTH
   a_rsp_ends_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy && $past(busy))
      else $error("result transfer without a query in flight");

   a_query_sets_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_cmd == CmdQuery) |=> busy)
      else $error("query transfer did not start the sequencer");

   a_write_no_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_cmd == CmdTableWrite) |=> !busy && !rsp_valid)
      else $error("table write disturbed the sequencer");

   a_octave_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SX) |-> (6'(oct_ff) < oct_lim))
      else $error("octave counter ran past the limit");
`endif

endmodule

FILE: dv/testbench.sv
// self-checking bench for fractal_perlin_noise_2d_core: table loads, noise queries, csr writes
// depends on fpn_pkg and the core; expected noise is typed or from a bit-exact predictor below
module testbench;
   import fpn_pkg::*;

   localparam int unsigned CycleLimit = 3000000;
   localparam int unsigned ItemsPerSegment = 98;

   typedef struct {
      logic               cmd;
      logic [7:0]         index;
      logic [7:0]         value;
      logic signed [31:0] x;
      logic signed [31:0] y;
      bit                 typed;
      logic signed [16:0] noise;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_cmd = CmdTableWrite;
   logic [7:0] req_table_index = '0;
   logic [7:0] req_table_value = '0;
   logic signed [31:0] req_coord_x = '0;
   logic signed [31:0] req_coord_y = '0;
   logic rsp_valid;
   logic signed [16:0] rsp_noise_value;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [3:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   logic [7:0] perm_copy [256];
   logic [4:0] octave_setting = 5'd4;
   logic [15:0] persistence_setting = 16'd32768;
   logic [15:0] lacunarity_setting = 16'd8192;

   logic signed [16:0] noise_expected [$];
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   int unsigned idle_pct = 31;
   bit start_up = 0;

   fractal_perlin_noise_2d_core u_top (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic longint fade5(longint t);
      longint t2, t3;
      t2 = (t * t) >>> 16;
      t3 = (t2 * t) >>> 16;
      return (t3 * (655360 + 6 * t2 - 15 * t)) >>> 16;
   endfunction

   function automatic longint blend(longint f, longint a, longint b);
      return a + ((f * (b - a)) >>> 16);
   endfunction

   function automatic longint corner_grad(logic [7:0] h, longint x, longint y);
      longint u, v, r1, r2;
      u  = h[2] ? y : x;
      v  = h[2] ? x : y;
      r1 = h[0] ? -u : u;
      r2 = h[1] ? -2 * v : 2 * v;
      return r1 + r2;
   endfunction

   function automatic longint octave_noise(logic [23:0] lx, logic [23:0] ly);
      logic [7:0] xi, yi, pa, pb;
      longint xf, yf, fu, fv, r1, r2;
      xi = lx[23:16];
      yi = ly[23:16];
      xf = longint'(lx[15:0]);
      yf = longint'(ly[15:0]);
      fu = fade5(xf);
      fv = fade5(yf);
      pa = perm_copy[xi];
      pb = perm_copy[8'(xi + 8'd1)];
      r1 = blend(fu, corner_grad(perm_copy[8'(pa + yi)], xf, yf),
                 corner_grad(perm_copy[8'(pb + yi)], xf - 65536, yf));
      r2 = blend(fu, corner_grad(perm_copy[8'(pa + yi + 8'd1)], xf, yf - 65536),
                 corner_grad(perm_copy[8'(pb + yi + 8'd1)], xf - 65536, yf - 65536));
      return blend(fv, r1, r2);
   endfunction

   function automatic logic signed [16:0] predict_noise(logic signed [31:0] x,
                                                        logic signed [31:0] y);
      int unsigned n;
      longint total, amp, amp_sum, freq, s, mag, q;
      logic [63:0] px, py;
      n = (octave_setting == 0) ? 1 : (octave_setting > 16) ? 16 : octave_setting;
      total = 0;
      amp = 65536;
      amp_sum = 0;
      freq = 4096;
      for (int unsigned i = 0; i < n; i++) begin
         px = longint'(x) * freq;
         py = longint'(y) * freq;
         s = total + ((octave_noise(px[35:12], py[35:12]) * amp) >>> 16);
         if (s > 64'sd2147483647) s = 64'sd2147483647;
         if (s < -64'sd2147483648) s = -64'sd2147483648;
         total = s;
         amp_sum = (amp_sum + amp) & 64'hFFFFFF;
         amp = (amp * persistence_setting) >>> 16;
         freq = (freq * lacunarity_setting) >>> 12;
         if (freq > 64'hFFFFFFFF) freq = 64'hFFFFFFFF;
      end
      mag = (total < 0) ? -total : total;
      q = (amp_sum == 0) ? 0 : (mag <<< 14) / amp_sum;
      if (total < 0) q = -q;
      if (q > 65535) q = 65535;
      if (q < -65536) q = -65536;
      return q[16:0];
   endfunction

   task automatic send_item(logic cmd, logic [7:0] index, logic [7:0] value,
                            logic signed [31:0] x, logic signed [31:0] y,
                            bit typed = 0, logic signed [16:0] noise = '0);
      req_cmd <= cmd;
      req_table_index <= index;
      req_table_value <= value;
      req_coord_x <= x;
      req_coord_y <= y;
      start <= 1'b1;
      start_up = 1;
      do @(posedge clock); while (busy);
      if (cmd == CmdTableWrite) perm_copy[index] = value;
      else noise_expected.push_back(typed ? noise : predict_noise(x, y));
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         start_up = 0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
   endtask

   task automatic drain();
      if (start_up) begin
         start <= 1'b0;
         start_up = 0;
      end
      do @(posedge clock); while (noise_expected.size() != 0 || busy);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] regnum, logic [31:0] data);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {regnum, 2'b00};
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (regnum)
         RegOctaves:     octave_setting = data[4:0];
         RegPersistence: persistence_setting = data[15:0];
         RegLacunarity:  lacunarity_setting = data[15:0];
         default: ;
      endcase
   endtask

   task automatic pick_settings();
      logic [31:0] oct, pers, lac;
      case ($urandom_range(5))
         0: oct = 0;
         1: oct = 1;
         2: oct = 16;
         3: oct = 31;
         default: oct = $urandom_range(1, 8);
      endcase
      case ($urandom_range(3))
         0: pers = 0;
         1: pers = 65535;
         default: pers = $urandom;
      endcase
      case ($urandom_range(4))
         0: lac = 0;
         1: lac = 65535;
         2: lac = 4096;
         default: lac = $urandom;
      endcase
      csr_write(RegOctaves, oct);
      csr_write(RegPersistence, pers);
      csr_write(RegLacunarity, lac);
   endtask

   function automatic logic signed [31:0] random_coord();
      case ($urandom_range(9))
         0: return 32'sh80000000;
         1: return 32'sh7FFFFFFF;
         2: return $urandom_range(3) << 16;
         3, 4, 5: return $signed($urandom_range(2097151)) - 32'sd1048576;
         default: return $urandom;
      endcase
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (noise_expected.size() == 0) begin
            $error("noise_value: no transfer expected, got %0d", rsp_noise_value);
            error_count++;
         end else begin
            logic signed [16:0] want;
            want = noise_expected.pop_front();
            if (rsp_noise_value !== want) begin
               $error("noise_value: expected %0d, got %0d", want, rsp_noise_value);
               error_count++;
            end
         end
      end
   end

   stim_row_type directed [18] = '{
      '{CmdQuery, 8'd0, 8'd0, 32'sh00000000, 32'sh00000000, 1, 17'sd0},
      '{CmdQuery, 8'd0, 8'd0, 32'sh7FFF0000, 32'sh80000000, 1, 17'sd0},
      '{CmdQuery, 8'd0, 8'd0, 32'shFFFF0000, 32'sh00050000, 1, 17'sd0},
      '{CmdQuery, 8'd0, 8'd0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 0, 17'sd0},
      '{CmdQuery, 8'd0, 8'd0, 32'sh80000000, 32'sh80000000, 0, 17'sd0},
      '{CmdQuery, 8'd0, 8'd0, 32'shFFFFFFFF, 32'sh00000001, 0, 17'sd0},
      '{CmdQuery, 8'd0, 8'd0, 32'sh00008000, 32'sh00008000, 0, 17'sd0},
      '{CmdQuery, 8'd0, 8'd0, 32'sh0000FFFF, 32'shFFFF0001, 0, 17'sd0},
      '{CmdTableWrite, 8'd0, 8'd255, 32'sh0, 32'sh0, 0, 17'sd0},
      '{CmdTableWrite, 8'd255, 8'd0, 32'sh0, 32'sh0, 0, 17'sd0},
      '{CmdTableWrite, 8'd1, 8'd255, 32'shFFFFFFFF, 32'shFFFFFFFF, 0, 17'sd0},
      '{CmdQuery, 8'd0, 8'd0, 32'sh00FF4000, 32'sh00FFC000, 0, 17'sd0},
      '{CmdQuery, 8'd0, 8'd0, 32'shFF004000, 32'sh0000C000, 0, 17'sd0},
      '{CmdTableWrite, 8'd128, 8'd127, 32'sh0, 32'sh0, 0, 17'sd0},
      '{CmdQuery, 8'd255, 8'd255, 32'sh12345678, 32'shEDCBA987, 0, 17'sd0},
      '{CmdQuery, 8'd0, 8'd0, 32'sh00013333, 32'sh0002CCCD, 0, 17'sd0},
      '{CmdQuery, 8'd0, 8'd0, 32'shFFFE8000, 32'sh00018000, 0, 17'sd0},
      '{CmdQuery, 8'd0, 8'd0, 32'sh40000000, 32'shC0000000, 0, 17'sd0}
   };

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < 256; i++) send_item(CmdTableWrite, 8'(i), 8'($urandom), 0, 0);
      foreach (directed[i])
         send_item(directed[i].cmd, directed[i].index, directed[i].value,
                   directed[i].x, directed[i].y, directed[i].typed, directed[i].noise);
      drain();
      csr_write(RegOctaves, 32'd16);
      csr_write(RegPersistence, 32'd65535);
      csr_write(RegLacunarity, 32'd65535);
      send_item(CmdQuery, 8'd0, 8'd0, 32'sh7FFFFFFF, 32'sh80000000);
      send_item(CmdQuery, 8'd0, 8'd0, 32'sh00012345, 32'shFFFE1234);
      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 31 : (phase == 1) ? 84 : 0;
         for (int seg = 0; seg < 5; seg++) begin
            drain();
            pick_settings();
            for (int k = 0; k < ItemsPerSegment; k++) begin
               if ($urandom_range(7) == 0)
                  send_item(CmdTableWrite, 8'($urandom), 8'($urandom), $urandom, $urandom);
               else
                  send_item(CmdQuery, 8'($urandom), 8'($urandom), random_coord(),
                            random_coord());
            end
         end
      end
      drain();
      repeat (300) @(posedge clock);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

FILE: files.f
sv/fpn_pkg.sv
sv/fpn_perm_ram.sv
sv/fpn_divider.sv
sv/fractal_perlin_noise_2d_core.sv
dv/testbench.sv
